@@ sv/mjm_pkg.sv @@
// ----------------------------------------------------------------------------
// mjm_pkg: shared types and constants of the maze junction mapper
// Payload structs, edge table word, motion and junction codes, FSM states.
// ----------------------------------------------------------------------------
package mjm_pkg;

  localparam int NODES_DEFAULT  = 16;
  localparam int SENSOR_BITS    = 12;
  localparam int CUTOFF_BITS    = 12;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_CUTOFF   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_CUTOFF = 4'd1;

  localparam logic [CUTOFF_BITS-1:0] LINE_CUTOFF_RESET   = 12'd2000;
  localparam logic [CUTOFF_BITS-1:0] CENTER_CUTOFF_RESET = 12'd1000;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_LEFT     = 3'd1;
  localparam logic [2:0] CMD_RIGHT    = 3'd2;
  localparam logic [2:0] CMD_AROUND   = 3'd3;
  localparam logic [2:0] CMD_STRAIGHT = 3'd4;

  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_END      = 3'd1;
  localparam logic [2:0] CLS_FOUR_WAY = 3'd2;
  localparam logic [2:0] CLS_TEE      = 3'd3;
  localparam logic [2:0] CLS_RIGHT_ST = 3'd4;
  localparam logic [2:0] CLS_LEFT_ST  = 3'd5;
  localparam logic [2:0] CLS_RIGHT    = 3'd6;
  localparam logic [2:0] CLS_LEFT     = 3'd7;

  localparam logic [2:0] DIR_NONE       = 3'd5;
  localparam logic [2:0] EDGE_DIR_START = 3'd0;
  localparam logic [2:0] EDGE_DIR_BACK  = 3'd2;

  localparam logic [1:0] TURN_LEFT     = 2'd1;
  localparam logic [1:0] TURN_RIGHT    = 2'd3;
  localparam logic [1:0] TURN_STRAIGHT = 2'd0;
  localparam logic [1:0] TURN_BACK     = 2'd2;

  typedef struct packed {
    logic                   func;
    logic [SENSOR_BITS-1:0] sensor0;
    logic [SENSOR_BITS-1:0] sensor1;
    logic [SENSOR_BITS-1:0] sensor2;
    logic [SENSOR_BITS-1:0] sensor3;
    logic [SENSOR_BITS-1:0] sensor4;
    logic [SENSOR_BITS-1:0] sensor5;
    logic [SENSOR_BITS-1:0] sensor6;
    logic [SENSOR_BITS-1:0] sensor7;
  } mjm_in_t;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] junction_class;
    logic [3:0] node_now;
    logic [1:0] heading;
    logic       map_full;
  } mjm_out_t;

  typedef struct packed {
    logic       used;
    logic [2:0] dir;
  } edge_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CLASS,
    ST_MAP,
    ST_MAP2,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_t;

endpackage

@@ sv/maze_junction_mapper_core.sv @@
// ----------------------------------------------------------------------------
// maze_junction_mapper_core: line maze junction classifier and graph mapper
// Sequence: a scan request compares each sensor to the line cutoff, then
//   classifies; a decide request uses 12 steps of the shared comparator,
//   up to 6 table writes for new edges, and a read then a check per edge
//   table entry walked. A new request is taken only once the last result
//   is registered; the walk reads the edge table one entry at a time.
// Reset: synchronous; after it the edge table sweeps all NODES*NODES entries
//   before the first request is taken; configuration writes are taken at once.
// ----------------------------------------------------------------------------
module maze_junction_mapper_core #(
  parameter int NODES = mjm_pkg::NODES_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mjm_pkg::mjm_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mjm_pkg::mjm_out_t                     out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mjm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mjm_pkg::CUTOFF_BITS-1:0]       cfg_data
);
  import mjm_pkg::*;

  localparam int NW  = $clog2(NODES);
  localparam int CW  = $clog2(NODES + 1);
  localparam int NXW = NW + 4;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  localparam logic [3:0] STEP_SCAN_LAST = 4'd7;
  localparam logic [3:0] STEP_MID3      = 4'd8;
  localparam logic [3:0] STEP_MID4      = 4'd9;
  localparam logic [3:0] STEP_GT3       = 4'd10;
  localparam logic [3:0] STEP_GT4       = 4'd11;

  state_t state, state_next;

  logic [CUTOFF_BITS-1:0] line_cut;
  logic [CUTOFF_BITS-1:0] center_cut;
  mjm_in_t                item;
  logic [3:0]             step;
  logic [7:0]             w;
  logic                   m3, m4, g3, g4;
  logic [7:0]             flags;
  logic [NODES-1:0]       mapped;
  logic [NW-1:0]          cur;
  logic [CW-1:0]          nfree;
  logic [1:0]             frame;
  logic [2:0]             pend;
  logic [NW-1:0]          widx;
  logic                   pass;
  logic [2:0]             r_cmd;
  logic [2:0]             r_cls;
  logic                   r_full;

  logic                   tbl_ready;
  logic                   wr_en;
  logic [NW-1:0]          wr_row, wr_col;
  edge_word_t             wr_word;
  edge_word_t             rd_word;

  logic [SENSOR_BITS-1:0] cmp_a, cmp_b;
  logic                   lt;

  logic [2:0]             cls;
  logic [2:0]             req;
  logic                   all_w, r2, l2, mid;
  logic [1:0]             turn;
  logic                   tbl_full;
  logic [1:0]             f0, f1, f2, f3;
  logic                   ent_ok;
  logic                   take;
  logic [2:0]             take_cmd;
  logic [NXW-1:0]         node_ext;

  mjm_edge_table #(.NODES(NODES), .NW(NW)) u_table (
    .clk     (clk),
    .rst     (rst),
    .ready   (tbl_ready),
    .wr_en   (wr_en),
    .wr_row  (wr_row),
    .wr_col  (wr_col),
    .wr_word (wr_word),
    .rd_row  (cur),
    .rd_col  (widx),
    .rd_word (rd_word)
  );

  assign in_ready  = (state == ST_IDLE) && tbl_ready;
  assign cfg_ready = 1'b1;

  // shared comparator
  always_comb begin
    cmp_b = line_cut;
    case (step[2:0])
      3'd0: cmp_a = item.sensor0;
      3'd1: cmp_a = item.sensor1;
      3'd2: cmp_a = item.sensor2;
      3'd3: cmp_a = item.sensor3;
      3'd4: cmp_a = item.sensor4;
      3'd5: cmp_a = item.sensor5;
      3'd6: cmp_a = item.sensor6;
      default: cmp_a = item.sensor7;
    endcase
    case (step)
      STEP_MID3: begin
        cmp_a = item.sensor3;
        cmp_b = center_cut;
      end
      STEP_MID4: begin
        cmp_a = item.sensor4;
        cmp_b = center_cut;
      end
      STEP_GT3: begin
        cmp_a = line_cut;
        cmp_b = item.sensor3;
      end
      STEP_GT4: begin
        cmp_a = line_cut;
        cmp_b = item.sensor4;
      end
      default: ;
    endcase
  end

  assign lt = cmp_a < cmp_b;

  // junction classification
  always_comb begin
    all_w = &flags;
    r2    = &flags[1:0];
    l2    = &flags[7:6];
    mid   = m3 && m4;
    cls   = CLS_NONE;
    req   = 3'b000;
    if (all_w && w[7] && w[6] && w[1] && w[0]) begin
      cls = CLS_END;
    end else if (all_w && w[4] && w[3]) begin
      cls = CLS_FOUR_WAY;
      req = 3'b111;
    end else if (all_w && g3 && g4) begin
      cls = CLS_TEE;
      req = 3'b011;
    end else if (mid && r2) begin
      cls = CLS_RIGHT_ST;
      req = 3'b110;
    end else if (mid && l2) begin
      cls = CLS_LEFT_ST;
      req = 3'b101;
    end else if (r2) begin
      cls = CLS_RIGHT;
    end else if (l2) begin
      cls = CLS_LEFT;
    end
  end

  // exit selection on the word read back
  always_comb begin
    f0       = frame;
    f1       = frame + TURN_LEFT;
    f2       = frame + TURN_BACK;
    f3       = frame + TURN_RIGHT;
    ent_ok   = (rd_word.dir != DIR_NONE) && !rd_word.used;
    take     = 1'b0;
    take_cmd = CMD_NONE;
    if (!pass) begin
      if (ent_ok && rd_word.dir == {1'b0, f1}) begin
        take     = 1'b1;
        take_cmd = CMD_RIGHT;
      end else if (ent_ok && rd_word.dir == {1'b0, f3}) begin
        take     = 1'b1;
        take_cmd = CMD_LEFT;
      end else if (ent_ok && rd_word.dir == {1'b0, f0}) begin
        take     = 1'b1;
        take_cmd = CMD_STRAIGHT;
      end
    end else if (ent_ok && rd_word.dir == {1'b0, f2}) begin
      take     = 1'b1;
      take_cmd = CMD_AROUND;
    end
  end

  always_comb begin
    if (pend[0]) begin
      turn = TURN_LEFT;
    end else if (pend[1]) begin
      turn = TURN_RIGHT;
    end else begin
      turn = TURN_STRAIGHT;
    end
  end

  assign tbl_full = (nfree == CW'(NODES));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    wr_en        = 1'b0;
    wr_row       = cur;
    wr_col       = NW'(nfree);
    wr_word.used = 1'b0;
    wr_word.dir  = {1'b0, frame + turn};
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (step == STEP_GT4 || (step == STEP_SCAN_LAST && !item.func)) begin
          state_next = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (!item.func || cls == CLS_NONE || cls == CLS_RIGHT || cls == CLS_LEFT) begin
          state_next = ST_DONE;
        end else if (cls == CLS_END) begin
          state_next = ST_WALK_RD;
        end else begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (pend == 3'b000) begin
          state_next = ST_WALK_RD;
        end else if (!tbl_full) begin
          wr_en      = 1'b1;
          state_next = ST_MAP2;
        end
      end
      ST_MAP2: begin
        wr_en       = 1'b1;
        wr_row      = NW'(nfree);
        wr_col      = cur;
        wr_word.dir = {1'b0, frame + turn + TURN_BACK};
        state_next  = ST_MAP;
      end
      ST_WALK_RD: begin
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        wr_row       = cur;
        wr_col       = widx;
        wr_word.used = 1'b1;
        wr_word.dir  = rd_word.dir;
        if (take) begin
          wr_en      = 1'b1;
          state_next = ST_DONE;
        end else if (!pass) begin
          if (widx == LAST_NODE && cur == NW'(0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_WALK_RD;
          end
        end else if (NW'(widx + 1'b1) == cur) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_cut   <= LINE_CUTOFF_RESET;
      center_cut <= CENTER_CUTOFF_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LINE_CUTOFF) begin
        line_cut <= cfg_data;
      end else if (cfg_index == REG_CENTER_CUTOFF) begin
        center_cut <= cfg_data;
      end
    end
  end

  // mapping state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags  <= '0;
      mapped <= '0;
      cur    <= NW'(1);
      nfree  <= CW'(2);
      frame  <= '0;
    end else begin
      case (state)
        ST_CLASS: begin
          if (!item.func) begin
            flags <= flags | w;
          end else begin
            if (cls != CLS_NONE) begin
              flags <= '0;
            end
            if (req != 3'b000) begin
              mapped[cur] <= 1'b1;
            end
          end
        end
        ST_MAP2: begin
          nfree <= nfree + 1'b1;
        end
        ST_WALK_CHK: begin
          if (take) begin
            cur <= widx;
            if (take_cmd != CMD_STRAIGHT) begin
              frame <= rd_word.dir[1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_IDLE) begin
      step <= '0;
    end else if (state == ST_CMP) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item <= in_data;
      end
      ST_CMP: begin
        case (step)
          STEP_MID3: m3 <= lt;
          STEP_MID4: m4 <= lt;
          STEP_GT3:  g3 <= lt;
          STEP_GT4:  g4 <= lt;
          default:   w[step[2:0]] <= lt;
        endcase
      end
      ST_CLASS: begin
        r_full <= 1'b0;
        r_cls  <= item.func ? cls : CLS_NONE;
        if (item.func && cls == CLS_RIGHT) begin
          r_cmd <= CMD_RIGHT;
        end else if (item.func && cls == CLS_LEFT) begin
          r_cmd <= CMD_LEFT;
        end else begin
          r_cmd <= CMD_NONE;
        end
        pend <= mapped[cur] ? 3'b000 : req;
        widx <= cur;
        pass <= 1'b0;
      end
      ST_MAP: begin
        widx <= cur;
        pass <= 1'b0;
        if (pend != 3'b000 && tbl_full) begin
          r_full <= 1'b1;
          if (pend[0]) begin
            pend[0] <= 1'b0;
          end else if (pend[1]) begin
            pend[1] <= 1'b0;
          end else begin
            pend[2] <= 1'b0;
          end
        end
      end
      ST_MAP2: begin
        if (pend[0]) begin
          pend[0] <= 1'b0;
        end else if (pend[1]) begin
          pend[1] <= 1'b0;
        end else begin
          pend[2] <= 1'b0;
        end
      end
      ST_WALK_CHK: begin
        if (take) begin
          r_cmd <= take_cmd;
        end else if (!pass && widx == LAST_NODE) begin
          widx <= '0;
          pass <= 1'b1;
        end else begin
          widx <= widx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  assign node_ext = NXW'(cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data.command        <= r_cmd;
      out_data.junction_class <= r_cls;
      out_data.node_now       <= node_ext[3:0];
      out_data.heading        <= frame;
      out_data.map_full       <= r_full;
    end
  end

`ifndef NO_ASSERTIONS
  a_nfree_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= CW'(NODES))
    else $error("free node count beyond table size");

  a_frame_walk: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && frame != $past(frame)) |-> $past(state) == ST_WALK_CHK)
    else $error("heading changed outside exit selection");

  a_node_walk: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cur != $past(cur)) |-> $past(state) == ST_WALK_CHK)
    else $error("node changed outside exit selection");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");
`endif

endmodule

@@ sv/mjm_edge_table.sv @@
// ----------------------------------------------------------------------------
// mjm_edge_table: edge direction and used-flag memory
// One word per ordered node pair, one write (once ready) and one registered read a cycle.
// After reset a sweep loads every entry, one per cycle, before ready rises.
// ----------------------------------------------------------------------------
module mjm_edge_table #(
  parameter int NODES = mjm_pkg::NODES_DEFAULT,
  parameter int NW    = $clog2(NODES)
) (
  input  logic                clk,
  input  logic                rst,
  output logic                ready,
  input  logic                wr_en,
  input  logic [NW-1:0]       wr_row,
  input  logic [NW-1:0]       wr_col,
  input  mjm_pkg::edge_word_t wr_word,
  input  logic [NW-1:0]       rd_row,
  input  logic [NW-1:0]       rd_col,
  output mjm_pkg::edge_word_t rd_word
);
  import mjm_pkg::*;

  localparam int DEPTH = 1 << (2 * NW);
  localparam logic [NW-1:0] LAST = NW'(NODES - 1);

  edge_word_t mem [0:DEPTH-1];

  logic [NW-1:0] clr_row;
  logic [NW-1:0] clr_col;
  edge_word_t    clr_word;

  always_comb begin
    clr_word.used = 1'b0;
    if (clr_row == NW'(0) && clr_col == NW'(1)) begin
      clr_word.dir = EDGE_DIR_START;
    end else if (clr_row == NW'(1) && clr_col == NW'(0)) begin
      clr_word.dir = EDGE_DIR_BACK;
    end else begin
      clr_word.dir = DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready   <= 1'b0;
      clr_row <= '0;
      clr_col <= '0;
    end else if (!ready) begin
      if (clr_col == LAST) begin
        clr_col <= '0;
        if (clr_row == LAST) begin
          ready <= 1'b1;
        end else begin
          clr_row <= clr_row + 1'b1;
        end
      end else begin
        clr_col <= clr_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[{clr_row, clr_col}] <= clr_word;
    end else if (wr_en) begin
      mem[{wr_row, wr_col}] <= wr_word;
    end
    rd_word <= mem[{rd_row, rd_col}];
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for maze_junction_mapper_core
// Drives scan and decide requests built as whole junction passes (flag scans
// followed by a decide sample) plus raw noise. The cutoffs are swept through
// their extremes between phases. Each request is run through a local copy of
// the flag, edge table, node and heading logic. Every result is compared
// field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import mjm_pkg::*;

  localparam int NODES              = NODES_DEFAULT;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int SETTLE_CYCLES      = 2 * NODES + 33;
  localparam int RANDOM_PHASE_ITEMS = 140;
  localparam int PRINT_LIMIT        = 40;

  localparam logic FUNC_SCAN   = 1'b0;
  localparam logic FUNC_DECIDE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_MAX = '1;
  localparam logic [SENSOR_BITS-1:0]    SENSOR_MAX    = '1;

  localparam logic [7:0] ALL_SENSORS = 8'hFF;
  localparam logic [7:0] SIDE_RIGHT  = 8'h03;
  localparam logic [7:0] SIDE_LEFT   = 8'hC0;
  localparam logic [7:0] CENTER_PAIR = 8'h18;
  localparam logic [7:0] OUTER_FOUR  = 8'hC3;

  typedef logic [SENSOR_BITS-1:0] reading_set_t [8];

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  mjm_in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  mjm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CUTOFF_BITS-1:0] cfg_data;

  // junction mapper state as predicted
  logic [CUTOFF_BITS-1:0] line_cut_m;
  logic [CUTOFF_BITS-1:0] center_cut_m;
  logic [7:0] flags_m;
  logic [2:0] dir_tab [NODES][NODES];
  bit used_tab [NODES][NODES];
  bit mapped_tab [NODES];
  int unsigned node_m;
  int unsigned free_m;
  logic [1:0] head_m;

  mjm_out_t pending_moves[$];
  mjm_out_t last_move;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit no_idle;

  maze_junction_mapper_core #(.NODES(NODES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------- prediction ----------------

  task automatic clear_mapper_state();
    int a;
    int b;
    line_cut_m   = LINE_CUTOFF_RESET;
    center_cut_m = CENTER_CUTOFF_RESET;
    flags_m      = '0;
    for (a = 0; a < NODES; a++) begin
      mapped_tab[a] = 1'b0;
      for (b = 0; b < NODES; b++) begin
        dir_tab[a][b]  = DIR_NONE;
        used_tab[a][b] = 1'b0;
      end
    end
    dir_tab[0][1] = EDGE_DIR_START;
    dir_tab[1][0] = EDGE_DIR_BACK;
    node_m = 1;
    free_m = 2;
    head_m = '0;
  endtask

  function automatic logic [2:0] rel_dir(logic [1:0] turn);
    logic [1:0] r;
    r = head_m + turn;
    return {1'b0, r};
  endfunction

  function automatic bit grow_edge(logic [1:0] turn);
    logic [1:0] out_dir;
    logic [1:0] back_dir;
    if (free_m >= NODES) return 1'b0;
    out_dir  = head_m + turn;
    back_dir = out_dir + TURN_BACK;
    dir_tab[node_m][free_m] = {1'b0, out_dir};
    dir_tab[free_m][node_m] = {1'b0, back_dir};
    free_m++;
    return 1'b1;
  endfunction

  function automatic bit map_junction(bit want_l, bit want_r, bit want_s);
    bit dropped;
    dropped = 1'b0;
    if (!mapped_tab[node_m]) begin
      if (want_l && !grow_edge(TURN_LEFT)) dropped = 1'b1;
      if (want_r && !grow_edge(TURN_RIGHT)) dropped = 1'b1;
      if (want_s && !grow_edge(TURN_STRAIGHT)) dropped = 1'b1;
    end
    mapped_tab[node_m] = 1'b1;
    return dropped;
  endfunction

  function automatic logic [2:0] take_exit();
    int unsigned c;
    int unsigned i;
    logic [2:0] d;
    c = node_m;
    for (i = c; i < NODES; i++) begin
      d = dir_tab[c][i];
      if (d == DIR_NONE || used_tab[c][i]) continue;
      if (d == rel_dir(TURN_LEFT)) begin
        head_m = d[1:0];
        used_tab[c][i] = 1'b1;
        node_m = i;
        return CMD_RIGHT;
      end
      if (d == rel_dir(TURN_RIGHT)) begin
        head_m = d[1:0];
        used_tab[c][i] = 1'b1;
        node_m = i;
        return CMD_LEFT;
      end
      if (d == rel_dir(TURN_STRAIGHT)) begin
        used_tab[c][i] = 1'b1;
        node_m = i;
        return CMD_STRAIGHT;
      end
    end
    for (i = 0; i < c; i++) begin
      d = dir_tab[c][i];
      if (d != DIR_NONE && !used_tab[c][i] && d == rel_dir(TURN_BACK)) begin
        head_m = d[1:0];
        used_tab[c][i] = 1'b1;
        node_m = i;
        return CMD_AROUND;
      end
    end
    return CMD_NONE;
  endfunction

  function automatic mjm_out_t predict_junction(mjm_in_t item);
    reading_set_t s;
    logic [7:0] w;
    logic [2:0] cmd;
    logic [2:0] cls;
    bit full;
    bit all_set;
    bit right_pair;
    bit left_pair;
    bit mid;
    mjm_out_t res;
    int i;
    s[0] = item.sensor0;
    s[1] = item.sensor1;
    s[2] = item.sensor2;
    s[3] = item.sensor3;
    s[4] = item.sensor4;
    s[5] = item.sensor5;
    s[6] = item.sensor6;
    s[7] = item.sensor7;
    for (i = 0; i < 8; i++) w[i] = s[i] < line_cut_m;
    cmd  = CMD_NONE;
    cls  = CLS_NONE;
    full = 1'b0;
    if (item.func == FUNC_SCAN) begin
      flags_m = flags_m | w;
    end else begin
      all_set    = flags_m == ALL_SENSORS;
      right_pair = (flags_m & SIDE_RIGHT) == SIDE_RIGHT;
      left_pair  = (flags_m & SIDE_LEFT) == SIDE_LEFT;
      mid        = s[3] < center_cut_m && s[4] < center_cut_m;
      if (all_set && (w & OUTER_FOUR) == OUTER_FOUR) begin
        cls = CLS_END;
        cmd = take_exit();
      end else if (all_set && (w & CENTER_PAIR) == CENTER_PAIR) begin
        cls  = CLS_FOUR_WAY;
        full = map_junction(1'b1, 1'b1, 1'b1);
        cmd  = take_exit();
      end else if (all_set && s[3] > line_cut_m && s[4] > line_cut_m) begin
        cls  = CLS_TEE;
        full = map_junction(1'b1, 1'b1, 1'b0);
        cmd  = take_exit();
      end else if (mid && right_pair) begin
        cls  = CLS_RIGHT_ST;
        full = map_junction(1'b0, 1'b1, 1'b1);
        cmd  = take_exit();
      end else if (mid && left_pair) begin
        cls  = CLS_LEFT_ST;
        full = map_junction(1'b1, 1'b0, 1'b1);
        cmd  = take_exit();
      end else if (right_pair) begin
        cls = CLS_RIGHT;
        cmd = CMD_RIGHT;
      end else if (left_pair) begin
        cls = CLS_LEFT;
        cmd = CMD_LEFT;
      end
      if (cls != CLS_NONE) flags_m = '0;
    end
    res.command        = cmd;
    res.junction_class = cls;
    res.node_now       = node_m[3:0];
    res.heading        = head_m;
    res.map_full       = full;
    return res;
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    mjm_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_moves.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_moves.pop_front();
        if (out_data.command !== want.command)
          report_mismatch($sformatf("command got %0d want %0d",
                                    out_data.command, want.command));
        if (out_data.junction_class !== want.junction_class)
          report_mismatch($sformatf("junction_class got %0d want %0d",
                                    out_data.junction_class, want.junction_class));
        if (out_data.node_now !== want.node_now)
          report_mismatch($sformatf("node_now got %0d want %0d",
                                    out_data.node_now, want.node_now));
        if (out_data.heading !== want.heading)
          report_mismatch($sformatf("heading got %0d want %0d",
                                    out_data.heading, want.heading));
        if (out_data.map_full !== want.map_full)
          report_mismatch($sformatf("map_full got %0d want %0d",
                                    out_data.map_full, want.map_full));
      end
    end
  end

  always @(negedge clk) begin
    if (no_idle) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 12);
  end

  // ---------------- stimulus ----------------

  function automatic logic [SENSOR_BITS-1:0] white_reading(logic [SENSOR_BITS-1:0] limit);
    if (limit == 0) return '0;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return limit - 1'b1;
      default: return SENSOR_BITS'($urandom_range(0, limit - 1));
    endcase
  endfunction

  function automatic logic [SENSOR_BITS-1:0] black_reading(logic [SENSOR_BITS-1:0] limit);
    case ($urandom_range(0, 3))
      0: return limit;
      1: return SENSOR_MAX;
      default: return SENSOR_BITS'($urandom_range(limit, SENSOR_MAX));
    endcase
  endfunction

  function automatic reading_set_t flat_readings(logic [7:0] white_mask);
    reading_set_t s;
    int i;
    for (i = 0; i < 8; i++) s[i] = white_mask[i] ? '0 : SENSOR_MAX;
    return s;
  endfunction

  function automatic reading_set_t mixed_readings(logic [7:0] white_mask);
    reading_set_t s;
    int i;
    for (i = 0; i < 8; i++)
      s[i] = white_mask[i] ? white_reading(line_cut_m) : black_reading(line_cut_m);
    return s;
  endfunction

  function automatic mjm_in_t build_item(logic f, reading_set_t s);
    mjm_in_t item;
    item.func    = f;
    item.sensor0 = s[0];
    item.sensor1 = s[1];
    item.sensor2 = s[2];
    item.sensor3 = s[3];
    item.sensor4 = s[4];
    item.sensor5 = s[5];
    item.sensor6 = s[6];
    item.sensor7 = s[7];
    return item;
  endfunction

  task automatic send_reading(input mjm_in_t item);
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    last_move = predict_junction(item);
    pending_moves.push_back(last_move);
    @(negedge clk);
  endtask

  task automatic write_cutoff(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CUTOFF_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LINE_CUTOFF) line_cut_m = val;
    else if (idx == REG_CENTER_CUTOFF) center_cut_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic scan_then_decide(input logic [7:0] scan_mask, input reading_set_t s);
    send_reading(build_item(FUNC_SCAN, flat_readings(scan_mask)));
    send_reading(build_item(FUNC_DECIDE, s));
  endtask

  // drive four-way junctions down fresh nodes until an edge gets dropped
  task automatic test_map_fill();
    int k;
    for (k = 0; k < 8 && !last_move.map_full; k++)
      scan_then_decide(ALL_SENSORS, flat_readings(CENTER_PAIR));
  endtask

  task automatic test_junction_classes();
    reading_set_t s;
    scan_then_decide(ALL_SENSORS, flat_readings(ALL_SENSORS));
    s = flat_readings('0);
    s[3] = line_cut_m;
    s[4] = line_cut_m;
    scan_then_decide(ALL_SENSORS, s);
    scan_then_decide(ALL_SENSORS, flat_readings('0));
    s = flat_readings('0);
    s[3] = center_cut_m - 1'b1;
    s[4] = center_cut_m - 1'b1;
    scan_then_decide(SIDE_RIGHT, s);
    scan_then_decide(SIDE_LEFT, s);
    scan_then_decide(SIDE_LEFT, flat_readings('0));
  endtask

  // unmatched decide must keep the flags for the next pass
  task automatic test_sticky_flags();
    scan_then_decide(8'h01, flat_readings('0));
    scan_then_decide(8'h02, flat_readings('0));
  endtask

  task automatic run_random_junctions(input int count);
    int done;
    int n;
    int k;
    logic [2:0] shape;
    logic [7:0] need;
    logic [7:0] mask;
    reading_set_t s;
    mjm_in_t item;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 99) < 20) begin
        item = {1'($urandom), $urandom, $urandom, $urandom};
        send_reading(item);
        done++;
      end else begin
        shape = 3'($urandom_range(CLS_END, CLS_LEFT));
        case (shape)
          CLS_END, CLS_FOUR_WAY, CLS_TEE: need = ALL_SENSORS;
          CLS_RIGHT_ST, CLS_RIGHT:        need = SIDE_RIGHT;
          default:                        need = SIDE_LEFT;
        endcase
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          mask = 8'($urandom & $urandom);
          if (k == n - 1) mask = mask | need;
          send_reading(build_item(FUNC_SCAN, mixed_readings(mask)));
        end
        s = mixed_readings(8'($urandom));
        case (shape)
          CLS_END: begin
            s[0] = white_reading(line_cut_m);
            s[1] = white_reading(line_cut_m);
            s[6] = white_reading(line_cut_m);
            s[7] = white_reading(line_cut_m);
          end
          CLS_FOUR_WAY: begin
            s[3] = white_reading(line_cut_m);
            s[4] = white_reading(line_cut_m);
          end
          CLS_TEE: begin
            s[3] = black_reading(line_cut_m);
            s[4] = black_reading(line_cut_m);
          end
          CLS_RIGHT_ST, CLS_LEFT_ST: begin
            s[3] = white_reading(center_cut_m);
            s[4] = white_reading(center_cut_m);
          end
          default: begin
          end
        endcase
        send_reading(build_item(FUNC_DECIDE, s));
        done += n + 1;
      end
    end
  endtask

  task automatic run_cutoff_phase(input logic [CUTOFF_BITS-1:0] line_val,
                                  input logic [CUTOFF_BITS-1:0] center_val);
    wait_for_results();
    write_cutoff(REG_LINE_CUTOFF, line_val);
    write_cutoff(REG_CENTER_CUTOFF, center_val);
    run_random_junctions(RANDOM_PHASE_ITEMS);
  endtask

  task automatic test_cutoff_settings();
    run_random_junctions(RANDOM_PHASE_ITEMS);
    run_cutoff_phase(SENSOR_MAX, SENSOR_MAX);
    run_cutoff_phase('0, '0);
    no_idle = 1'b1;
    run_cutoff_phase(12'd3000, 12'd2500);
    no_idle = 1'b0;
    run_cutoff_phase(12'd1500, SENSOR_MAX);
    run_cutoff_phase(CUTOFF_BITS'($urandom), CUTOFF_BITS'($urandom));
  endtask

  // writes past the last register must leave both cutoffs alone
  task automatic test_ignored_index();
    wait_for_results();
    write_cutoff(REG_LINE_CUTOFF, LINE_CUTOFF_RESET);
    write_cutoff(REG_CENTER_CUTOFF, CENTER_CUTOFF_RESET);
    write_cutoff(REG_INDEX_MAX, '0);
    write_cutoff(CFG_INDEX_BITS'($urandom_range(REG_CENTER_CUTOFF + 1, REG_INDEX_MAX)),
                 SENSOR_MAX);
    run_random_junctions(RANDOM_PHASE_ITEMS / 2);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_idle        = 1'b0;
    last_move      = '0;
    clear_mapper_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_map_fill();
    test_junction_classes();
    test_sticky_flags();
    test_cutoff_settings();
    test_ignored_index();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
